[rtl/pdor_pkg.sv]
package pdor_pkg;

    // default store capacity in bytes
    localparam int BUFFER_BYTES_DEF = 64;

    // walk positions: store index plus a 255-byte entry or option length
    localparam int POS_W = 10;

    // element and protocol codes
    localparam logic [7:0]  HDR_BYTE   = 8'h80;
    localparam logic [15:0] PROTO_IPCP = 16'h8021;
    localparam logic [7:0]  CMD_REQ    = 8'h01;
    localparam logic [7:0]  CMD_ACK    = 8'h02;
    localparam logic [7:0]  OPT_PRI    = 8'h81;
    localparam logic [7:0]  OPT_SEC    = 8'h83;
    localparam logic [7:0]  OPT_MIN    = 8'd6;

    // configuration register indexes
    localparam logic REG_PRIMARY   = 1'b0;
    localparam logic REG_SECONDARY = 1'b1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_HDR_RD,
        S_HDR_CHK,
        S_ENT,
        S_P0,
        S_P1,
        S_EL,
        S_CMD,
        S_ILEN,
        S_OP,
        S_CODE,
        S_OLEN,
        S_WR,
        S_E_RD,
        S_E_LD
    } state_t;

    // controller to output stage
    typedef struct packed {
        logic load;
        logic last;
        logic trunc;
        logic hdr;
    } emit_t;

endpackage

[rtl/pco_dns_option_rewriter.sv]
// PCO DNS option rewriter.
// Slave stream (s_*) carries one byte of a protocol configuration options
// element per request, tlast on the final byte. Bytes are stored in a
// single-port memory, one per cycle; bytes beyond BUFFER_BYTES are dropped
// and flagged in truncated. On the last byte the block stops taking input,
// checks the header and, for a good header, walks the stored element:
// protocol entries one by one and, in an IPCP configure-request, its
// options, rewriting each DNS address in place. The rewritten element then
// leaves on the master stream (m_*), each byte read from memory and then
// loaded into the output register, while the receiver is ready.
// The output register holds a byte while m_tready is low; input for the
// next element is taken again once the final byte is in that register.
// Configuration (cfg_*) is always ready; write it only while idle.
// Reset clears the fill count, the overflow flag, the output valid flag,
// the DNS registers and the sequencer; the byte store needs no clearing.
module pco_dns_option_rewriter #(
    parameter int BUFFER_BYTES = pdor_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    output logic [1:0]  m_tuser,   // [0] truncated, [1] header_ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [31:0]     primary_reg;
    logic [31:0]     secondary_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic [1:0]      out_user_reg;
    logic            out_free;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [7:0]      mem_wdata;
    logic [7:0]      mem_rdata;
    pdor_pkg::emit_t emit;

    assign cfg_ready = 1'b1;

    // DNS address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_reg   <= 32'd0;
            secondary_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pdor_pkg::REG_PRIMARY:   primary_reg   <= cfg_data;
                pdor_pkg::REG_SECONDARY: secondary_reg <= cfg_data;
                default:                 primary_reg   <= primary_reg;
            endcase
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_byte_reg <= mem_rdata;
            out_last_reg <= emit.last;
            out_user_reg <= {emit.hdr, emit.trunc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    pdor_mem #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pdor_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .in_byte       (s_tdata),
        .in_last       (s_tlast),
        .primary_dns   (primary_reg),
        .secondary_dns (secondary_reg),
        .out_free      (out_free),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .emit          (emit)
    );

endmodule

[rtl/pdor_mem.sv]
module pdor_mem #(
    parameter int DEPTH = pdor_pkg::BUFFER_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pdor_ctrl.sv]
module pdor_ctrl #(
    parameter int BUFFER_BYTES = pdor_pkg::BUFFER_BYTES_DEF,
    parameter int AW           = $clog2(BUFFER_BYTES),
    parameter int CW           = $clog2(BUFFER_BYTES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic [31:0]       primary_dns,
    input  logic [31:0]       secondary_dns,
    input  logic              out_free,
    output logic              mem_we,
    output logic [AW-1:0]     mem_addr,
    output logic [7:0]        mem_wdata,
    input  logic [7:0]        mem_rdata,
    output pdor_pkg::emit_t   emit
);

    localparam int PW = pdor_pkg::POS_W;

    pdor_pkg::state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] n_reg, n_next;
    logic          trunc_reg, trunc_next;
    logic          hdr_reg, hdr_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [7:0]    elen_reg, elen_next;
    logic [7:0]    phi_reg, phi_next;
    logic [PW-1:0] lim_reg, lim_next;
    logic [PW-1:0] op_reg, op_next;
    logic [7:0]    code_reg, code_next;
    logic [7:0]    olen_reg, olen_next;
    logic [31:0]   addr_reg, addr_next;
    logic [1:0]    k_reg, k_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic [PW-1:0] pos;
    logic [PW-1:0] nw;
    logic [PW-1:0] pc3;
    logic          full;
    logic          is_dns;

    assign nw       = PW'(n_reg);
    assign pc3      = pc_reg + PW'(3);
    assign full     = (fill_reg >= CW'(BUFFER_BYTES));
    assign is_dns   = (code_reg == pdor_pkg::OPT_PRI) || (code_reg == pdor_pkg::OPT_SEC);
    assign mem_addr = pos[AW-1:0];

    // state and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdor_pkg::S_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        trunc_reg <= trunc_next;
        hdr_reg   <= hdr_next;
        pc_reg    <= pc_next;
        elen_reg  <= elen_next;
        phi_reg   <= phi_next;
        lim_reg   <= lim_next;
        op_reg    <= op_next;
        code_reg  <= code_next;
        olen_reg  <= olen_next;
        addr_reg  <= addr_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
    end

    // load, walk and emit sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        trunc_next = trunc_reg;
        hdr_next   = hdr_reg;
        pc_next    = pc_reg;
        elen_next  = elen_reg;
        phi_next   = phi_reg;
        lim_next   = lim_reg;
        op_next    = op_reg;
        code_next  = code_reg;
        olen_next  = olen_reg;
        addr_next  = addr_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = in_byte;
        pos        = '0;
        emit       = '{load: 1'b0, last: 1'b0, trunc: trunc_reg, hdr: hdr_reg};

        case (state_reg)
            pdor_pkg::S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!full)
                    begin
                        mem_we    = 1'b1;
                        pos       = PW'(fill_reg);
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        n_next     = full ? fill_reg : fill_reg + CW'(1);
                        trunc_next = ovf_reg | full;
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = pdor_pkg::S_HDR_RD;
                    end
                end
            end

            pdor_pkg::S_HDR_RD:
            begin
                pos        = '0;
                state_next = pdor_pkg::S_HDR_CHK;
            end

            pdor_pkg::S_HDR_CHK:
            begin
                hdr_next = (mem_rdata == pdor_pkg::HDR_BYTE);
                if (mem_rdata == pdor_pkg::HDR_BYTE)
                begin
                    pc_next    = PW'(1);
                    state_next = pdor_pkg::S_ENT;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = pdor_pkg::S_E_RD;
                end
            end

            // protocol entry: id high, id low, length
            pdor_pkg::S_ENT:
            begin
                if (pc_reg + PW'(2) >= nw)
                begin
                    idx_next   = '0;
                    state_next = pdor_pkg::S_E_RD;
                end
                else
                begin
                    pos        = pc_reg;
                    state_next = pdor_pkg::S_P0;
                end
            end

            pdor_pkg::S_P0:
            begin
                phi_next   = mem_rdata;
                pos        = pc_reg + PW'(1);
                state_next = pdor_pkg::S_P1;
            end

            pdor_pkg::S_P1:
            begin
                code_next  = mem_rdata;
                pos        = pc_reg + PW'(2);
                state_next = pdor_pkg::S_EL;
            end

            pdor_pkg::S_EL:
            begin
                elen_next = mem_rdata;
                if ({phi_reg, code_reg} != pdor_pkg::PROTO_IPCP)
                begin
                    pc_next    = pc3 + PW'(mem_rdata);
                    state_next = pdor_pkg::S_ENT;
                end
                else
                begin
                    pc_next = pc3;
                    if (pc3 >= nw)
                    begin
                        idx_next   = '0;
                        state_next = pdor_pkg::S_E_RD;
                    end
                    else
                    begin
                        pos        = pc3;
                        state_next = pdor_pkg::S_CMD;
                    end
                end
            end

            // IPCP command byte, then its inner length
            pdor_pkg::S_CMD:
            begin
                if (mem_rdata != pdor_pkg::CMD_REQ)
                begin
                    pc_next    = pc_reg + PW'(elen_reg);
                    state_next = pdor_pkg::S_ENT;
                end
                else if (pc_reg + PW'(3) >= nw)
                begin
                    idx_next   = '0;
                    state_next = pdor_pkg::S_E_RD;
                end
                else
                begin
                    pos        = pc_reg + PW'(3);
                    state_next = pdor_pkg::S_ILEN;
                end
            end

            pdor_pkg::S_ILEN:
            begin
                lim_next   = pc_reg + PW'(mem_rdata);
                op_next    = pc_reg + PW'(4);
                state_next = pdor_pkg::S_OP;
            end

            // option walk
            pdor_pkg::S_OP:
            begin
                if (op_reg >= lim_reg)
                begin
                    pc_next    = pc_reg + PW'(elen_reg);
                    state_next = pdor_pkg::S_ENT;
                end
                else if (op_reg + PW'(1) >= nw)
                begin
                    idx_next   = '0;
                    state_next = pdor_pkg::S_E_RD;
                end
                else
                begin
                    pos        = op_reg;
                    state_next = pdor_pkg::S_CODE;
                end
            end

            pdor_pkg::S_CODE:
            begin
                code_next  = mem_rdata;
                pos        = op_reg + PW'(1);
                state_next = pdor_pkg::S_OLEN;
            end

            pdor_pkg::S_OLEN:
            begin
                olen_next = mem_rdata;
                if (is_dns)
                begin
                    // ack the request in place
                    mem_we    = 1'b1;
                    pos       = pc_reg;
                    mem_wdata = pdor_pkg::CMD_ACK;
                    if (mem_rdata < pdor_pkg::OPT_MIN)
                    begin
                        pc_next    = pc_reg + PW'(elen_reg);
                        state_next = pdor_pkg::S_ENT;
                    end
                    else if (op_reg + PW'(5) >= nw)
                    begin
                        idx_next   = '0;
                        state_next = pdor_pkg::S_E_RD;
                    end
                    else
                    begin
                        addr_next  = (code_reg == pdor_pkg::OPT_SEC && secondary_dns != 32'd0)
                                     ? secondary_dns : primary_dns;
                        k_next     = 2'd0;
                        state_next = pdor_pkg::S_WR;
                    end
                end
                else if (mem_rdata == 8'd0)
                begin
                    idx_next   = '0;
                    state_next = pdor_pkg::S_E_RD;
                end
                else
                begin
                    op_next    = op_reg + PW'(mem_rdata);
                    state_next = pdor_pkg::S_OP;
                end
            end

            // address bytes, first octet first
            pdor_pkg::S_WR:
            begin
                mem_we    = 1'b1;
                pos       = op_reg + PW'(2) + PW'(k_reg);
                mem_wdata = addr_reg[31:24];
                addr_next = {addr_reg[23:0], 8'd0};
                k_next    = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    op_next    = op_reg + PW'(olen_reg);
                    state_next = pdor_pkg::S_OP;
                end
            end

            // stream the store out through the output register
            pdor_pkg::S_E_RD:
            begin
                pos = PW'(idx_reg);
                if (out_free)
                begin
                    state_next = pdor_pkg::S_E_LD;
                end
            end

            pdor_pkg::S_E_LD:
            begin
                emit.load = 1'b1;
                emit.last = (idx_reg + CW'(1) == n_reg);
                idx_next  = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == n_reg)
                begin
                    state_next = pdor_pkg::S_LOAD;
                end
                else
                begin
                    state_next = pdor_pkg::S_E_RD;
                end
            end

            default:
            begin
                state_next = pdor_pkg::S_LOAD;
            end
        endcase
    end

    // no input is taken while a byte is handed to the output stage
    a_no_load_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !emit.load)
        else $error("input accepted during emit");

    // emitted index stays inside the stored element
    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> (idx_reg < n_reg))
        else $error("emit index beyond element");

    // final byte returns the block to loading
    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.last) |=> (state_reg == pdor_pkg::S_LOAD))
        else $error("no return to load after last byte");

    // fill count never exceeds capacity
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(BUFFER_BYTES))
        else $error("fill count over capacity");

endmodule
